// File: hw/rtl/sdi_pkg.sv
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared types, codes and microprogram for the spring-damper integrator.
// ----------------------------------------------------------------------------
package sdi_pkg;

    localparam int VW = 32;
    localparam int FB = 16;
    localparam int PW = 2 * VW + 2;
    localparam int PC_W = 6;
    localparam int NUM_REGS = 7;

    localparam logic [VW:0] RECIP6 = 33'h0AAAAAAAB;

    typedef logic [1:0] t_op;
    localparam t_op OP_ADD  = 2'd0;
    localparam t_op OP_SUB  = 2'd1;
    localparam t_op OP_MUL  = 2'd2;
    localparam t_op OP_DIV6 = 2'd3;

    typedef logic [4:0] t_sel;
    localparam t_sel S_P     = 5'd0;
    localparam t_sel S_V     = 5'd1;
    localparam t_sel S_EP    = 5'd2;
    localparam t_sel S_EV    = 5'd3;
    localparam t_sel S_K     = 5'd4;
    localparam t_sel S_H     = 5'd5;
    localparam t_sel S_HH    = 5'd6;
    localparam t_sel S_F0    = 5'd7;
    localparam t_sel S_FM    = 5'd8;
    localparam t_sel S_FE    = 5'd9;
    localparam t_sel S_X     = 5'd10;
    localparam t_sel S_A2    = 5'd11;
    localparam t_sel S_A3    = 5'd12;
    localparam t_sel S_A4    = 5'd13;
    localparam t_sel S_B1    = 5'd14;
    localparam t_sel S_B2    = 5'd15;
    localparam t_sel S_B3    = 5'd16;
    localparam t_sel S_B4    = 5'd17;
    localparam t_sel S_Q     = 5'd18;
    localparam t_sel S_R     = 5'd19;
    localparam t_sel S_T     = 5'd20;
    localparam t_sel S_S1    = 5'd21;
    localparam t_sel S_S2    = 5'd22;
    localparam t_sel S_DAMP  = 5'd23;
    localparam t_sel S_IMASS = 5'd24;
    localparam t_sel S_KONE  = 5'd25;
    localparam t_sel S_KTWO  = 5'd26;

    localparam logic [2:0] R_K1    = 3'd0;
    localparam logic [2:0] R_K2    = 3'd1;
    localparam logic [2:0] R_DAMP  = 3'd2;
    localparam logic [2:0] R_IMASS = 3'd3;
    localparam logic [2:0] R_STEP  = 3'd4;
    localparam logic [2:0] R_SPOS  = 3'd5;
    localparam logic [2:0] R_SVEL  = 3'd6;

    typedef struct packed {
        t_op  op;
        t_sel a;
        t_sel b;
        t_sel dst;
    } t_uop;

    localparam logic [PC_W-1:0] PC_LAST = 6'd57;

    function automatic t_uop uop(input t_op op, input t_sel a, input t_sel b,
                                 input t_sel dst);
        t_uop u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.dst = dst;
        return u;
    endfunction

    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = uop(OP_ADD, S_KONE, S_KTWO, S_K);
            6'd1:  u = uop(OP_MUL, S_K, S_P, S_Q);
            6'd2:  u = uop(OP_SUB, S_F0, S_Q, S_Q);
            6'd3:  u = uop(OP_MUL, S_DAMP, S_V, S_R);
            6'd4:  u = uop(OP_SUB, S_Q, S_R, S_Q);
            6'd5:  u = uop(OP_MUL, S_IMASS, S_Q, S_B1);
            6'd6:  u = uop(OP_MUL, S_HH, S_B1, S_T);
            6'd7:  u = uop(OP_ADD, S_V, S_T, S_A2);
            6'd8:  u = uop(OP_MUL, S_HH, S_V, S_T);
            6'd9:  u = uop(OP_ADD, S_P, S_T, S_X);
            6'd10: u = uop(OP_MUL, S_K, S_X, S_Q);
            6'd11: u = uop(OP_SUB, S_FM, S_Q, S_Q);
            6'd12: u = uop(OP_MUL, S_DAMP, S_A2, S_R);
            6'd13: u = uop(OP_SUB, S_Q, S_R, S_Q);
            6'd14: u = uop(OP_MUL, S_IMASS, S_Q, S_B2);
            6'd15: u = uop(OP_MUL, S_HH, S_B2, S_T);
            6'd16: u = uop(OP_ADD, S_V, S_T, S_A3);
            6'd17: u = uop(OP_MUL, S_HH, S_A2, S_T);
            6'd18: u = uop(OP_ADD, S_P, S_T, S_X);
            6'd19: u = uop(OP_MUL, S_K, S_X, S_Q);
            6'd20: u = uop(OP_SUB, S_FM, S_Q, S_Q);
            6'd21: u = uop(OP_MUL, S_DAMP, S_A3, S_R);
            6'd22: u = uop(OP_SUB, S_Q, S_R, S_Q);
            6'd23: u = uop(OP_MUL, S_IMASS, S_Q, S_B3);
            6'd24: u = uop(OP_MUL, S_H, S_B3, S_T);
            6'd25: u = uop(OP_ADD, S_V, S_T, S_A4);
            6'd26: u = uop(OP_MUL, S_H, S_A3, S_T);
            6'd27: u = uop(OP_ADD, S_P, S_T, S_X);
            6'd28: u = uop(OP_MUL, S_K, S_X, S_Q);
            6'd29: u = uop(OP_SUB, S_FE, S_Q, S_Q);
            6'd30: u = uop(OP_MUL, S_DAMP, S_A4, S_R);
            6'd31: u = uop(OP_SUB, S_Q, S_R, S_Q);
            6'd32: u = uop(OP_MUL, S_IMASS, S_Q, S_B4);
            6'd33: u = uop(OP_ADD, S_A2, S_A2, S_S1);
            6'd34: u = uop(OP_ADD, S_V, S_S1, S_S1);
            6'd35: u = uop(OP_ADD, S_A3, S_A3, S_S2);
            6'd36: u = uop(OP_ADD, S_S2, S_A4, S_S2);
            6'd37: u = uop(OP_ADD, S_S1, S_S2, S_X);
            6'd38: u = uop(OP_ADD, S_B2, S_B2, S_S1);
            6'd39: u = uop(OP_ADD, S_B1, S_S1, S_S1);
            6'd40: u = uop(OP_ADD, S_B3, S_B3, S_S2);
            6'd41: u = uop(OP_ADD, S_S2, S_B4, S_S2);
            6'd42: u = uop(OP_ADD, S_S1, S_S2, S_S1);
            6'd43: u = uop(OP_MUL, S_H, S_X, S_T);
            6'd44: u = uop(OP_DIV6, S_T, S_T, S_T);
            6'd45: u = uop(OP_ADD, S_P, S_T, S_P);
            6'd46: u = uop(OP_MUL, S_H, S_S1, S_T);
            6'd47: u = uop(OP_DIV6, S_T, S_T, S_T);
            6'd48: u = uop(OP_ADD, S_V, S_T, S_V);
            6'd49: u = uop(OP_MUL, S_K, S_EP, S_Q);
            6'd50: u = uop(OP_SUB, S_F0, S_Q, S_Q);
            6'd51: u = uop(OP_MUL, S_DAMP, S_EV, S_R);
            6'd52: u = uop(OP_SUB, S_Q, S_R, S_Q);
            6'd53: u = uop(OP_MUL, S_IMASS, S_Q, S_B1);
            6'd54: u = uop(OP_MUL, S_H, S_EV, S_T);
            6'd55: u = uop(OP_ADD, S_EP, S_T, S_EP);
            6'd56: u = uop(OP_MUL, S_H, S_B1, S_T);
            6'd57: u = uop(OP_ADD, S_EV, S_T, S_EV);
            default: u = uop(OP_ADD, S_T, S_T, S_T);
        endcase
        return u;
    endfunction

endpackage

// File: hw/rtl/sdi_alu.sv
// ----------------------------------------------------------------------------
// sdi_alu
// Shared saturating Q16.16 unit: add, subtract, multiply, divide by six.
// ----------------------------------------------------------------------------
module sdi_alu import sdi_pkg::*; (
    input  t_op                   i_op,
    input  logic signed [VW-1:0]  i_a,
    input  logic signed [VW-1:0]  i_b,
    output logic signed [VW-1:0]  o_res,
    output logic                  o_sat
);

    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0]        ONE  = {{(VW-1){1'b0}}, 1'b1};

    logic signed [VW:0]   w_sum;
    logic signed [VW:0]   w_ma;
    logic signed [VW:0]   w_mb;
    logic signed [PW-1:0] w_prod;
    logic [VW-1:0]        w_mag;
    logic [VW-1:0]        w_quot;
    logic                 w_hi_ok;

    always_comb begin
        if (i_op == OP_SUB) begin
            w_sum = {i_a[VW-1], i_a} - {i_b[VW-1], i_b};
        end else begin
            w_sum = {i_a[VW-1], i_a} + {i_b[VW-1], i_b};
        end
    end

    assign w_mag = i_a[VW-1] ? (~i_a + ONE) : i_a;

    always_comb begin
        if (i_op == OP_DIV6) begin
            w_ma = {1'b0, w_mag};
            w_mb = RECIP6;
        end else begin
            w_ma = {i_a[VW-1], i_a};
            w_mb = {i_b[VW-1], i_b};
        end
    end

    assign w_prod  = w_ma * w_mb;
    assign w_quot  = {2'b00, w_prod[2*VW-1:VW+2]};
    assign w_hi_ok = (&w_prod[PW-1:VW+FB-1]) || !(|w_prod[PW-1:VW+FB-1]);

    always_comb begin
        o_sat = 1'b0;
        case (i_op)
            OP_ADD, OP_SUB: begin
                if (w_sum[VW] != w_sum[VW-1]) begin
                    o_sat = 1'b1;
                    o_res = w_sum[VW] ? VMIN : VMAX;
                end else begin
                    o_res = w_sum[VW-1:0];
                end
            end
            OP_MUL: begin
                if (!w_hi_ok) begin
                    o_sat = 1'b1;
                    o_res = w_prod[PW-1] ? VMIN : VMAX;
                end else begin
                    o_res = w_prod[VW+FB-1:FB];
                end
            end
            OP_DIV6: begin
                o_res = i_a[VW-1] ? (~w_quot + ONE) : w_quot;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/spring_damper_integrator_core.sv
// ----------------------------------------------------------------------------
// spring_damper_integrator_core
// RK4 and Euler steps of a mass-spring-damper on one shared Q16.16 unit.
// ----------------------------------------------------------------------------
// Each request runs 58 microcode steps on the single shared multiply/add
// unit, then its results are loaded into the output register. s_axis_tready
// is low while busy, until that load; no new request is taken before it.
// Reset (synchronous, active low): registers to defaults, state to zero.
module spring_damper_integrator_core import sdi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] force_now, [63:32] force_mid, [95:64] force_end
    input  logic [95:0]      s_axis_tdata,
    // [0] restart
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [31:0] rk4_position, [63:32] rk4_velocity,
    // [95:64] euler_position, [127:96] euler_velocity
    output logic [127:0]     m_axis_tdata,
    // [0] saturated
    output logic             m_axis_tuser,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data
);

    logic [30:0] r_k1, r_k2, r_damp, r_imass;
    logic [16:0] r_step;
    logic [31:0] r_spos, r_svel;

    logic signed [VW-1:0] r_p, r_v, r_ep, r_ev, r_k, r_f0, r_fm, r_fe;
    logic signed [VW-1:0] r_x, r_a2, r_a3, r_a4, r_b1, r_b2, r_b3, r_b4;
    logic signed [VW-1:0] r_q, r_r, r_t, r_s1, r_s2;

    logic            r_busy, r_pend, r_sat, r_ovalid;
    logic [PC_W-1:0] r_pc;
    logic [127:0]    r_odata;
    logic            r_osat;

    t_uop                 w_uop;
    logic signed [VW-1:0] w_a, w_b, w_res;
    logic                 w_sat, w_acc, w_load;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_busy;
    assign w_acc         = s_axis_tvalid && !r_busy;
    assign w_load        = r_pend && (!r_ovalid || m_axis_tready);
    assign w_uop         = ucode(r_pc);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_osat;

    function automatic logic signed [VW-1:0] pick(input t_sel s,
            input logic signed [VW-1:0] p, v, ep, ev, k, f0, fm, fe,
            input logic signed [VW-1:0] x, a2, a3, a4, b1, b2, b3, b4,
            input logic signed [VW-1:0] q, r, t, s1, s2,
            input logic [30:0] k1, k2, dmp, im, input logic [16:0] st);
        logic signed [VW-1:0] o;
        case (s)
            S_P:     o = p;
            S_V:     o = v;
            S_EP:    o = ep;
            S_EV:    o = ev;
            S_K:     o = k;
            S_H:     o = {15'd0, st};
            S_HH:    o = {16'd0, st[16:1]};
            S_F0:    o = f0;
            S_FM:    o = fm;
            S_FE:    o = fe;
            S_X:     o = x;
            S_A2:    o = a2;
            S_A3:    o = a3;
            S_A4:    o = a4;
            S_B1:    o = b1;
            S_B2:    o = b2;
            S_B3:    o = b3;
            S_B4:    o = b4;
            S_Q:     o = q;
            S_R:     o = r;
            S_T:     o = t;
            S_S1:    o = s1;
            S_S2:    o = s2;
            S_DAMP:  o = {1'b0, dmp};
            S_IMASS: o = {1'b0, im};
            S_KONE:  o = {1'b0, k1};
            S_KTWO:  o = {1'b0, k2};
            default: o = '0;
        endcase
        return o;
    endfunction

    assign w_a = pick(w_uop.a, r_p, r_v, r_ep, r_ev, r_k, r_f0, r_fm, r_fe,
                      r_x, r_a2, r_a3, r_a4, r_b1, r_b2, r_b3, r_b4,
                      r_q, r_r, r_t, r_s1, r_s2, r_k1, r_k2, r_damp, r_imass, r_step);
    assign w_b = pick(w_uop.b, r_p, r_v, r_ep, r_ev, r_k, r_f0, r_fm, r_fe,
                      r_x, r_a2, r_a3, r_a4, r_b1, r_b2, r_b3, r_b4,
                      r_q, r_r, r_t, r_s1, r_s2, r_k1, r_k2, r_damp, r_imass, r_step);

    sdi_alu u_alu (
        .i_op  (w_uop.op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_res),
        .o_sat (w_sat)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1    <= 31'd65536;
            r_k2    <= 31'd65536;
            r_damp  <= 31'd65536;
            r_imass <= 31'd65536;
            r_step  <= 17'd655;
            r_spos  <= '0;
            r_svel  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                R_K1:    r_k1    <= i_cfg_data[30:0];
                R_K2:    r_k2    <= i_cfg_data[30:0];
                R_DAMP:  r_damp  <= i_cfg_data[30:0];
                R_IMASS: r_imass <= i_cfg_data[30:0];
                R_STEP:  r_step  <= i_cfg_data[16:0];
                R_SPOS:  r_spos  <= i_cfg_data;
                R_SVEL:  r_svel  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pend   <= 1'b0;
            r_pc     <= '0;
            r_ovalid <= 1'b0;
            r_sat    <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_acc) begin
                r_busy <= 1'b1;
                r_pc   <= '0;
                r_sat  <= 1'b0;
            end else if (r_busy && !r_pend) begin
                r_sat <= r_sat | w_sat;
                if (r_pc == PC_LAST) begin
                    r_pend <= 1'b1;
                end else begin
                    r_pc <= r_pc + {{(PC_W-1){1'b0}}, 1'b1};
                end
            end else if (w_load) begin
                r_pend <= 1'b0;
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_odata <= {r_ev, r_ep, r_v, r_p};
            r_osat  <= r_sat;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p  <= '0;
            r_v  <= '0;
            r_ep <= '0;
            r_ev <= '0;
        end else if (w_acc) begin
            if (s_axis_tuser) begin
                r_p  <= r_spos;
                r_ep <= r_spos;
                r_v  <= r_svel;
                r_ev <= r_svel;
            end
        end else if (r_busy && !r_pend) begin
            case (w_uop.dst)
                S_P:     r_p  <= w_res;
                S_V:     r_v  <= w_res;
                S_EP:    r_ep <= w_res;
                S_EV:    r_ev <= w_res;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_f0 <= s_axis_tdata[31:0];
            r_fm <= s_axis_tdata[63:32];
            r_fe <= s_axis_tdata[95:64];
        end else if (r_busy && !r_pend) begin
            case (w_uop.dst)
                S_K:     r_k  <= w_res;
                S_X:     r_x  <= w_res;
                S_A2:    r_a2 <= w_res;
                S_A3:    r_a3 <= w_res;
                S_A4:    r_a4 <= w_res;
                S_B1:    r_b1 <= w_res;
                S_B2:    r_b2 <= w_res;
                S_B3:    r_b3 <= w_res;
                S_B4:    r_b4 <= w_res;
                S_Q:     r_q  <= w_res;
                S_R:     r_r  <= w_res;
                S_T:     r_t  <= w_res;
                S_S1:    r_s1 <= w_res;
                S_S2:    r_s2 <= w_res;
                default: ;
            endcase
        end
    end

endmodule
